>>> hw/rtl/jtpf_pkg.sv
// shared types and character constants for the topic/payload frame parser
// no dependencies

package jtpf_pkg;

    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_FIRST = 8'h21;
    localparam logic [7:0] CH_LAST  = 8'h7E;

    localparam int WIN_LEN = 8;

    localparam logic [1:0] KIND_TOPIC   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    typedef struct packed {
        logic top;
        logic pld;
        logic well_formed;
    } hdr_t;

endpackage

>>> hw/rtl/jtpf_hdr_match.sv
// field header matcher over an eight byte window of the frame
// depends on jtpf_pkg

module jtpf_hdr_match
(
    input  logic [8*jtpf_pkg::WIN_LEN-1:0] win,
    output jtpf_pkg::hdr_t                 hdr
);

    logic [7:0] b [jtpf_pkg::WIN_LEN];
    logic       lead;

    always_comb
    begin
        for (int i = 0; i < jtpf_pkg::WIN_LEN; i++)
        begin
            b[i] = win[8*(jtpf_pkg::WIN_LEN-1-i) +: 8];
        end
        lead = (b[0] == jtpf_pkg::CH_OPEN || b[0] == jtpf_pkg::CH_COMMA)
               && b[1] == jtpf_pkg::CH_QUOTE;
        hdr.top = lead && b[2] == jtpf_pkg::CH_T && b[3] == jtpf_pkg::CH_O
                  && b[4] == jtpf_pkg::CH_P;
        hdr.pld = lead && b[2] == jtpf_pkg::CH_P && b[3] == jtpf_pkg::CH_L
                  && b[4] == jtpf_pkg::CH_D;
        hdr.well_formed = b[5] == jtpf_pkg::CH_QUOTE && b[6] == jtpf_pkg::CH_COLON
                          && b[7] == jtpf_pkg::CH_QUOTE;
    end

endmodule

>>> hw/rtl/json_topic_payload_frame_parser.sv
// top level of the topic/payload frame parser: frame memory, scan and emit
// depends on jtpf_pkg and jtpf_hdr_match

// While a frame is being gathered, each input byte is taken as it comes. On
// the closing brace the block stalls its input: S_CR and S_LF append CR and
// LF, then the frame memory (one synchronous read port) is streamed once
// through an eight byte window, one byte a cycle. Each topic or payload
// character then goes through a memory read, a load and a transfer, and
// the summary through one more step; the transfer and the summary wait out
// any output stall. Topic and payload are kept as position and length
// inside the frame memory, so the scan and the emit both run off that
// single read port.

module json_topic_payload_frame_parser
#(
    parameter int BUF_LEN     = 64,
    parameter int TOPIC_LEN   = 32,
    parameter int PAYLOAD_LEN = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] char_value,
    output logic [1:0] token_count,
    output logic       last
);

    localparam int AW   = $clog2(BUF_LEN);
    localparam int FW   = $clog2(BUF_LEN + 1);
    localparam int JW   = $clog2(BUF_LEN + 9);
    localparam int TLIM = TOPIC_LEN - 3;
    localparam int PLIM = PAYLOAD_LEN - 3;
    localparam int LMAX = (TLIM > PLIM) ? TLIM : PLIM;
    localparam int MW   = $clog2(LMAX + 1);
    localparam int TW   = $clog2(TLIM + 1);
    localparam int PW   = $clog2(PLIM + 1);
    localparam int WB   = 8 * jtpf_pkg::WIN_LEN;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CR,
        S_LF,
        S_SCAN,
        S_START,
        S_EMIT_RD,
        S_EMIT_LD,
        S_OUT,
        S_SUM
    } state_t;

    state_t          state_reg;
    logic [FW-1:0]   fill_reg;
    logic            gathering_reg;

    logic [7:0]      frame_mem [BUF_LEN];
    logic [7:0]      mem_rdata_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;

    logic [JW-1:0]   j_reg;
    logic            issue_done_reg;
    logic            sv_valid_reg;
    logic            sv_zero_reg;
    logic            sv_last_reg;
    logic [JW-1:0]   dj_reg;
    logic [WB-1:0]   win_reg;
    logic [WB-1:0]   win_next;
    logic [7:0]      nb;
    jtpf_pkg::hdr_t  hdr;

    logic            meas_act_reg;
    logic            meas_pld_reg;
    logic [MW-1:0]   meas_n_reg;
    logic [JW-1:0]   meas_pos_reg;
    logic [MW-1:0]   meas_lim;
    logic            meas_fin;
    logic [MW-1:0]   meas_len;

    logic [1:0]      count_reg;
    logic [JW-1:0]   tpos_reg;
    logic [TW-1:0]   tlen_reg;
    logic [JW-1:0]   ppos_reg;
    logic [PW-1:0]   plen_reg;

    logic            phase_pld_reg;
    logic [MW-1:0]   e_reg;
    logic [JW-1:0]   emit_addr;

    logic            out_valid_reg;
    logic [1:0]      kind_reg;
    logic [7:0]      char_reg;
    logic [1:0]      count_out_reg;
    logic            last_reg;

    logic            graphic;
    logic            fits_close;
    logic            j_in_fill;
    logic [JW-1:0]   j_end;

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign char_value  = char_reg;
    assign token_count = count_out_reg;
    assign last        = last_reg;

    assign graphic    = (byte_in >= jtpf_pkg::CH_FIRST) && (byte_in <= jtpf_pkg::CH_LAST);
    assign fits_close = (JW'(fill_reg) + JW'(3)) <= JW'(BUF_LEN);
    assign j_in_fill  = j_reg < JW'(fill_reg);
    assign j_end      = JW'(fill_reg) + JW'(7);

    assign nb       = sv_zero_reg ? 8'h00 : mem_rdata_reg;
    assign win_next = {win_reg[WB-9:0], nb};
    assign meas_lim = meas_pld_reg ? MW'(PLIM) : MW'(TLIM);

    assign emit_addr = (phase_pld_reg ? ppos_reg : tpos_reg) + JW'(e_reg);

    jtpf_hdr_match u_hdr
    (
        .win (win_next),
        .hdr (hdr)
    );

    // value length measurement, one byte per scan step
    always_comb
    begin
        meas_fin = 1'b0;
        meas_len = meas_n_reg;
        if (meas_act_reg && sv_valid_reg)
        begin
            if (nb == jtpf_pkg::CH_QUOTE || nb == 8'h00)
            begin
                meas_fin = 1'b1;
            end
            else if (meas_n_reg + MW'(1) == meas_lim)
            begin
                meas_fin = 1'b1;
                meas_len = meas_n_reg + MW'(1);
            end
        end
    end

    // frame memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = fill_reg[AW-1:0];
        mem_wdata = byte_in;
        mem_re    = 1'b0;
        mem_raddr = j_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && graphic)
                begin
                    if (byte_in == jtpf_pkg::CH_OPEN)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                    end
                    else if (gathering_reg && byte_in != jtpf_pkg::CH_CLOSE)
                    begin
                        mem_we = (fill_reg < FW'(BUF_LEN));
                    end
                    else if (gathering_reg)
                    begin
                        mem_we = fits_close;
                    end
                end
            end
            S_CR:
            begin
                mem_we    = 1'b1;
                mem_wdata = jtpf_pkg::CH_CR;
            end
            S_LF:
            begin
                mem_we    = 1'b1;
                mem_wdata = jtpf_pkg::CH_LF;
            end
            S_SCAN:
            begin
                mem_re = j_in_fill && !issue_done_reg;
            end
            S_EMIT_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = emit_addr[AW-1:0];
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= frame_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            gathering_reg  <= 1'b0;
            j_reg          <= '0;
            issue_done_reg <= 1'b0;
            sv_valid_reg   <= 1'b0;
            sv_zero_reg    <= 1'b0;
            sv_last_reg    <= 1'b0;
            dj_reg         <= '0;
            win_reg        <= '0;
            meas_act_reg   <= 1'b0;
            meas_pld_reg   <= 1'b0;
            meas_n_reg     <= '0;
            meas_pos_reg   <= '0;
            count_reg      <= '0;
            tpos_reg       <= '0;
            tlen_reg       <= '0;
            ppos_reg       <= '0;
            plen_reg       <= '0;
            phase_pld_reg  <= 1'b0;
            e_reg          <= '0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= '0;
            char_reg       <= '0;
            count_out_reg  <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && graphic)
                    begin
                        if (byte_in == jtpf_pkg::CH_OPEN)
                        begin
                            gathering_reg <= 1'b1;
                            fill_reg      <= FW'(1);
                        end
                        else if (gathering_reg && byte_in != jtpf_pkg::CH_CLOSE)
                        begin
                            if (fill_reg < FW'(BUF_LEN))
                            begin
                                fill_reg <= fill_reg + FW'(1);
                            end
                            else
                            begin
                                gathering_reg <= 1'b0;
                                fill_reg      <= '0;
                            end
                        end
                        else if (gathering_reg)
                        begin
                            if (fits_close)
                            begin
                                fill_reg  <= fill_reg + FW'(1);
                                state_reg <= S_CR;
                            end
                            else
                            begin
                                gathering_reg <= 1'b0;
                                fill_reg      <= '0;
                            end
                        end
                    end
                end
                S_CR:
                begin
                    fill_reg  <= fill_reg + FW'(1);
                    state_reg <= S_LF;
                end
                S_LF:
                begin
                    fill_reg       <= fill_reg + FW'(1);
                    gathering_reg  <= 1'b0;
                    j_reg          <= '0;
                    issue_done_reg <= 1'b0;
                    sv_valid_reg   <= 1'b0;
                    win_reg        <= '0;
                    meas_act_reg   <= 1'b0;
                    count_reg      <= '0;
                    tlen_reg       <= '0;
                    plen_reg       <= '0;
                    state_reg      <= S_SCAN;
                end
                S_SCAN:
                begin
                    // issue side of the stream
                    if (!issue_done_reg)
                    begin
                        sv_valid_reg <= 1'b1;
                        sv_zero_reg  <= !j_in_fill;
                        sv_last_reg  <= (j_reg == j_end);
                        dj_reg       <= j_reg;
                        j_reg        <= j_reg + JW'(1);
                        if (j_reg == j_end)
                        begin
                            issue_done_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        sv_valid_reg <= 1'b0;
                    end
                    // window side of the stream
                    if (sv_valid_reg)
                    begin
                        win_reg <= win_next;
                        if (meas_act_reg)
                        begin
                            if (meas_fin)
                            begin
                                meas_act_reg <= 1'b0;
                                if (meas_pld_reg)
                                begin
                                    ppos_reg <= meas_pos_reg;
                                    plen_reg <= PW'(meas_len);
                                end
                                else
                                begin
                                    tpos_reg <= meas_pos_reg;
                                    tlen_reg <= TW'(meas_len);
                                end
                            end
                            else
                            begin
                                meas_n_reg <= meas_n_reg + MW'(1);
                            end
                        end
                        if (hdr.top)
                        begin
                            count_reg <= {1'b0, hdr.well_formed};
                        end
                        else if (hdr.pld && hdr.well_formed)
                        begin
                            count_reg <= (count_reg == 2'd2) ? 2'd2 : count_reg + 2'd1;
                        end
                        if ((hdr.top || hdr.pld) && hdr.well_formed)
                        begin
                            meas_act_reg <= 1'b1;
                            meas_pld_reg <= hdr.pld;
                            meas_n_reg   <= '0;
                            meas_pos_reg <= dj_reg + JW'(1);
                        end
                        if (sv_last_reg)
                        begin
                            state_reg <= S_START;
                        end
                    end
                end
                S_START:
                begin
                    e_reg <= '0;
                    if (tlen_reg != '0)
                    begin
                        phase_pld_reg <= 1'b0;
                        state_reg     <= S_EMIT_RD;
                    end
                    else if (plen_reg != '0)
                    begin
                        phase_pld_reg <= 1'b1;
                        state_reg     <= S_EMIT_RD;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= jtpf_pkg::KIND_SUMMARY;
                        char_reg      <= '0;
                        count_out_reg <= count_reg;
                        last_reg      <= 1'b1;
                        state_reg     <= S_SUM;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD:
                begin
                    out_valid_reg <= 1'b1;
                    kind_reg      <= phase_pld_reg ? jtpf_pkg::KIND_PAYLOAD
                                                   : jtpf_pkg::KIND_TOPIC;
                    char_reg      <= mem_rdata_reg;
                    count_out_reg <= '0;
                    last_reg      <= 1'b0;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (!phase_pld_reg && (e_reg + MW'(1) != MW'(tlen_reg)))
                        begin
                            e_reg     <= e_reg + MW'(1);
                            state_reg <= S_EMIT_RD;
                        end
                        else if (phase_pld_reg && (e_reg + MW'(1) != MW'(plen_reg)))
                        begin
                            e_reg     <= e_reg + MW'(1);
                            state_reg <= S_EMIT_RD;
                        end
                        else if (!phase_pld_reg && plen_reg != '0)
                        begin
                            e_reg         <= '0;
                            phase_pld_reg <= 1'b1;
                            state_reg     <= S_EMIT_RD;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                            kind_reg      <= jtpf_pkg::KIND_SUMMARY;
                            char_reg      <= '0;
                            count_out_reg <= count_reg;
                            last_reg      <= 1'b1;
                            state_reg     <= S_SUM;
                        end
                    end
                end
                S_SUM:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        last_reg      <= 1'b0;
                        fill_reg      <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sim/tb_json_topic_payload_frame_parser.sv
// testbench for json_topic_payload_frame_parser: directed and random byte streams
// checked against an in-bench frame scanner; depends on jtpf_pkg and the rtl top
`timescale 1ns / 100ps

module tb_json_topic_payload_frame_parser;

    localparam int FRAME_MAX   = 64;
    localparam int VALUE_MAX   = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [1:0] cnt;
        logic       last;
    } frame_item_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] byte_in;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] kind;
    logic [7:0] char_value;
    logic [1:0] token_count;
    logic       last;

    frame_item_t expected_items[$];
    logic [7:0]  frame_bytes[FRAME_MAX];
    int          frame_fill;
    bit          in_frame;
    logic [7:0]  topic_chars[VALUE_MAX];
    logic [7:0]  payload_chars[VALUE_MAX];
    int          topic_len;
    int          payload_len;

    int  errors;
    int  cycles;
    int  burst_left;
    int  stall_mode;
    bit  hold_go;
    int  hold_cnt;
    int  sent;

    json_topic_payload_frame_parser dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_in     (byte_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .char_value  (char_value),
        .token_count (token_count),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // long hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_go && hold_cnt < HOLD_CYCLES)
            hold_cnt <= hold_cnt + 1;
    end

    always @(posedge clk)
    begin
        if (cycles % 97 == 0)
            stall_mode <= $urandom_range(0, 3);
        if (hold_go && hold_cnt < HOLD_CYCLES)
            out_stall <= 1'b1;
        else if (stall_mode == 1)
            out_stall <= ($urandom_range(0, 3) == 0);
        else if (stall_mode == 2)
            out_stall <= ($urandom_range(0, 3) != 0);
        else if (stall_mode == 3)
            out_stall <= ((cycles % 8) < 3);
        else
            out_stall <= 1'b0;
    end

    // result check
    always @(posedge clk)
    begin
        frame_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_items.size() == 0)
            begin
                $error("unexpected result kind=%0d char=%02h", kind, char_value);
                errors++;
            end
            else
            begin
                want = expected_items.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind expected %0d actual %0d", want.kind, kind);
                    errors++;
                end
                if (char_value !== want.ch)
                begin
                    $error("char_value expected %02h actual %02h", want.ch, char_value);
                    errors++;
                end
                if (token_count !== want.cnt)
                begin
                    $error("token_count expected %0d actual %0d", want.cnt, token_count);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last expected %0d actual %0d", want.last, last);
                    errors++;
                end
            end
        end
    end

    function automatic logic [7:0] frame_at(int k);
        if (k < frame_fill && k < FRAME_MAX)
            return frame_bytes[k];
        return 8'h00;
    endfunction

    function automatic void store_byte(logic [7:0] b);
        if (frame_fill >= FRAME_MAX)
        begin
            in_frame = 1'b0;
            frame_fill = 0;
        end
        else
        begin
            frame_bytes[frame_fill] = b;
            frame_fill++;
        end
    endfunction

    function automatic int copy_value(int base, bit is_topic);
        logic [7:0] c;
        int n;
        n = 0;
        if (frame_at(base) != jtpf_pkg::CH_QUOTE || frame_at(base + 1) != jtpf_pkg::CH_COLON ||
            frame_at(base + 2) != jtpf_pkg::CH_QUOTE)
            return 0;
        for (int i = 3; i < VALUE_MAX; i++)
        begin
            c = frame_at(base + i);
            if (c == jtpf_pkg::CH_QUOTE || c == 8'h00)
                break;
            if (is_topic)
                topic_chars[n] = c;
            else
                payload_chars[n] = c;
            n++;
        end
        if (is_topic)
            topic_len = n;
        else
            payload_len = n;
        return 1;
    endfunction

    function automatic void predict_frame(logic [7:0] b);
        frame_item_t it;
        logic [7:0] c0;
        int count;
        if (b < jtpf_pkg::CH_FIRST || b > jtpf_pkg::CH_LAST)
            return;
        if (b == jtpf_pkg::CH_OPEN)
        begin
            in_frame = 1'b1;
            frame_fill = 0;
            store_byte(b);
            return;
        end
        if (!in_frame)
            return;
        if (b != jtpf_pkg::CH_CLOSE)
        begin
            store_byte(b);
            return;
        end
        if (frame_fill + 3 > FRAME_MAX)
        begin
            in_frame = 1'b0;
            frame_fill = 0;
            return;
        end
        store_byte(jtpf_pkg::CH_CLOSE);
        store_byte(jtpf_pkg::CH_CR);
        store_byte(jtpf_pkg::CH_LF);
        in_frame = 1'b0;
        count = 0;
        topic_len = 0;
        payload_len = 0;
        for (int p = 0; p < frame_fill; p++)
        begin
            c0 = frame_at(p);
            if ((c0 == jtpf_pkg::CH_OPEN || c0 == jtpf_pkg::CH_COMMA) &&
                frame_at(p + 1) == jtpf_pkg::CH_QUOTE)
            begin
                if (frame_at(p + 2) == jtpf_pkg::CH_T && frame_at(p + 3) == jtpf_pkg::CH_O &&
                    frame_at(p + 4) == jtpf_pkg::CH_P)
                    count = copy_value(p + 5, 1'b1);
                if (frame_at(p + 2) == jtpf_pkg::CH_P && frame_at(p + 3) == jtpf_pkg::CH_L &&
                    frame_at(p + 4) == jtpf_pkg::CH_D)
                begin
                    count += copy_value(p + 5, 1'b0);
                    if (count > 2)
                        count = 2;
                end
            end
        end
        for (int i = 0; i < topic_len; i++)
        begin
            it = '{jtpf_pkg::KIND_TOPIC, topic_chars[i], 2'd0, 1'b0};
            expected_items.push_back(it);
        end
        for (int i = 0; i < payload_len; i++)
        begin
            it = '{jtpf_pkg::KIND_PAYLOAD, payload_chars[i], 2'd0, 1'b0};
            expected_items.push_back(it);
        end
        it = '{jtpf_pkg::KIND_SUMMARY, 8'h00, 2'(count), 1'b1};
        expected_items.push_back(it);
        frame_fill = 0;
    endfunction

    task automatic send_byte(logic [7:0] b);
        byte_in <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_frame(b);
        sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] value_char();
        logic [7:0] c;
        c = 8'($urandom_range(jtpf_pkg::CH_FIRST, jtpf_pkg::CH_LAST));
        if (c == jtpf_pkg::CH_QUOTE)
            c = jtpf_pkg::CH_COLON;
        return c;
    endfunction

    task automatic send_random_frame(int value_top);
        int fields;
        int sel;
        int vlen;
        string name;
        send_byte(jtpf_pkg::CH_OPEN);
        fields = $urandom_range(1, 3);
        for (int f = 0; f < fields; f++)
        begin
            if (f > 0)
                send_byte(($urandom_range(0, 9) == 0) ? value_char() : jtpf_pkg::CH_COMMA);
            sel = $urandom_range(0, 4);
            name = (sel < 2) ? "TOP" : (sel < 4) ? "PLD" : "TOQ";
            send_byte(jtpf_pkg::CH_QUOTE);
            send_text(name);
            send_byte(jtpf_pkg::CH_QUOTE);
            send_byte(($urandom_range(0, 9) == 0) ? value_char() : jtpf_pkg::CH_COLON);
            send_byte(jtpf_pkg::CH_QUOTE);
            vlen = ($urandom_range(0, 11) == 0) ? value_top : $urandom_range(0, 8);
            for (int i = 0; i < vlen; i++)
            begin
                if ($urandom_range(0, 29) == 0)
                    send_byte(8'($urandom_range(0, 255)));
                else
                    send_byte(value_char());
            end
            if ($urandom_range(0, 9) != 0)
                send_byte(jtpf_pkg::CH_QUOTE);
        end
        if ($urandom_range(0, 19) != 0)
            send_byte(jtpf_pkg::CH_CLOSE);
    endtask

    task automatic wait_drained();
        while (expected_items.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
    endtask

    task automatic test_ignored_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h20);
        send_byte(8'h7F);
        send_byte(jtpf_pkg::CH_CLOSE);
        send_byte(8'h41);
        send_byte(8'h21);
        send_byte(8'h7E);
    endtask

    task automatic test_basic_frame();
        send_text("{\"TOP\":\"ab\",\"PLD\":\"c\"}");
    endtask

    task automatic test_restart_and_open_value();
        send_text("{x{\"TOP\":\"q\"}");
        send_text("{\"TOP\"x,\"PLD\":\"zz}");
    endtask

    task automatic test_saturation();
        send_text("{\"PLD\":\"a\",\"PLD\":\"b\",\"PLD\":\"c\"}");
        send_text("{\"TOP\":\"a\",\"TOP\"!\"b\",\"PLD\":\"\"}");
    endtask

    task automatic test_long_values();
        send_text("{\"TOP\":\"");
        for (int i = 0; i < 34; i++)
            send_byte(8'h61 + 8'(i % 26));
        send_text("\"}");
    endtask

    task automatic test_overflow();
        send_byte(jtpf_pkg::CH_OPEN);
        for (int i = 0; i < 70; i++)
            send_byte(value_char());
        send_byte(jtpf_pkg::CH_CLOSE);
        for (int n = 61; n <= 62; n++)
        begin
            send_text("{\"PLD\":\"");
            for (int i = 8; i < n; i++)
                send_byte(value_char());
            send_byte(jtpf_pkg::CH_CLOSE);
        end
    endtask

    task automatic test_random_frames();
        while (sent < 470)
        begin
            if ($urandom_range(0, 7) == 0)
                send_byte(8'($urandom_range(0, 255)));
            else
                send_random_frame(($urandom_range(0, 3) == 0) ? 60 : 33);
        end
    endtask

    task automatic test_output_hold_off();
        hold_go = 1'b1;
        for (int i = 0; i < 3; i++)
            send_text("{\"TOP\":\"abcd\",\"PLD\":\"wxyz\"}");
        in_valid <= 1'b0;
        while (hold_cnt < HOLD_CYCLES)
            @(posedge clk);
        hold_go = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        byte_in = 8'h00;
        out_stall = 1'b0;
        errors = 0;
        cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        hold_go = 1'b0;
        hold_cnt = 0;
        sent = 0;
        frame_fill = 0;
        in_frame = 1'b0;
        topic_len = 0;
        payload_len = 0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_bytes();
        test_basic_frame();
        test_restart_and_open_value();
        test_saturation();
        test_long_values();
        test_overflow();
        test_output_hold_off();
        test_random_frames();

        in_valid <= 1'b0;
        wait_drained();
        repeat (200)
            @(posedge clk);
        if (errors == 0 && expected_items.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
